### rtl/bist_pkg.sv
// Package for the bounded integer set table.
// Sizes, field widths, empty-set limits and operation codes; no dependencies.
`timescale 1ns / 1ps

package bist_pkg;

    localparam int CAPACITY = 16;
    localparam int WORD_W   = 32;
    localparam int COUNT_W  = 5;
    localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W    = $clog2(CAPACITY + 1);

    localparam logic signed [WORD_W-1:0] EMPTY_MIN = {1'b0, {(WORD_W-1){1'b1}}};
    localparam logic signed [WORD_W-1:0] EMPTY_MAX = {1'b1, {(WORD_W-1){1'b0}}};

    typedef enum logic [1:0] {
        FUNC_INSERT = 2'd0,
        FUNC_REMOVE = 2'd1,
        FUNC_QUERY  = 2'd2,
        FUNC_CLEAR  = 2'd3
    } bist_func_t;

endpackage

### rtl/bist_ram.sv
// Simple dual-port RAM: one write port, one read port with registered data.
// Generic; no package dependencies.
`timescale 1ns / 1ps

module bist_ram #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 32,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

### rtl/bounded_integer_set_table.sv
// Top level of the bounded integer set table.
// Depends on bist_pkg and bist_ram.
`timescale 1ns / 1ps

// Holds up to CAPACITY distinct signed 32-bit values in insertion order in one
// RAM with a registered read. One word is handled at a time. Every operation
// other than clear scans the n held entries through the RAM read port, one
// per cycle, before the result is loaded; a remove of a held value adds a
// compaction pass that reads and writes back the entries above the removed
// one. Clear skips the scan and goes straight to loading the result.
// The result register lets a new word be accepted while the last result waits.
module bounded_integer_set_table
    import bist_pkg::*;
(
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic [1:0]               s_func,
    input  logic signed [WORD_W-1:0] s_value,
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic                     m_was_member,
    output logic                     m_insert_rejected,
    output logic [COUNT_W-1:0]       m_count,
    output logic signed [WORD_W-1:0] m_minimum,
    output logic signed [WORD_W-1:0] m_maximum
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_APPLY,
        ST_SHIFT,
        ST_OUT
    } state_t;

    state_t                   state_reg;
    bist_func_t               func_reg;
    logic signed [WORD_W-1:0] value_reg;
    logic signed [WORD_W-1:0] lo_reg;
    logic signed [WORD_W-1:0] hi_reg;
    logic                     member_reg;
    logic                     rejected_reg;
    logic [IDX_W-1:0]         pos_reg;
    logic [CNT_W-1:0]         count_reg;
    logic [CNT_W-1:0]         ptr_reg;
    logic                     pend_reg;
    logic [IDX_W-1:0]         pidx_reg;
    logic                     m_valid_reg;

    logic                     issue;
    logic                     ram_wr_en;
    logic [IDX_W-1:0]         ram_wr_addr;
    logic [WORD_W-1:0]        ram_wr_data;
    logic [WORD_W-1:0]        ram_rd_data;
    logic signed [WORD_W-1:0] rd_word;
    logic                     full;
    logic                     do_insert;

    assign rd_word   = ram_rd_data;
    assign full      = (count_reg >= CNT_W'(CAPACITY));
    assign issue     = ((state_reg == ST_SCAN) || (state_reg == ST_SHIFT))
                       && (ptr_reg < count_reg);
    assign do_insert = (state_reg == ST_APPLY) && (func_reg == FUNC_INSERT)
                       && !member_reg && !full;

    always_comb begin
        ram_wr_en   = 1'b0;
        ram_wr_addr = count_reg[IDX_W-1:0];
        ram_wr_data = value_reg;
        if (do_insert) begin
            ram_wr_en = 1'b1;
        end else if ((state_reg == ST_SHIFT) && pend_reg) begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = pidx_reg - IDX_W'(1);
            ram_wr_data = ram_rd_data;
        end
    end

    bist_ram #(
        .DEPTH (CAPACITY),
        .WIDTH (WORD_W)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (issue),
        .rd_addr (ptr_reg[IDX_W-1:0]),
        .rd_data (ram_rd_data)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            pend_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (m_valid_reg && m_ready && (state_reg != ST_OUT)) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (s_valid) begin
                        func_reg     <= bist_func_t'(s_func);
                        value_reg    <= s_value;
                        lo_reg       <= EMPTY_MIN;
                        hi_reg       <= EMPTY_MAX;
                        member_reg   <= 1'b0;
                        rejected_reg <= 1'b0;
                        ptr_reg      <= '0;
                        pend_reg     <= 1'b0;
                        if (bist_func_t'(s_func) == FUNC_CLEAR) begin
                            count_reg <= '0;
                            state_reg <= ST_OUT;
                        end else begin
                            state_reg <= ST_SCAN;
                        end
                    end
                end
                ST_SCAN: begin
                    pend_reg <= issue;
                    pidx_reg <= ptr_reg[IDX_W-1:0];
                    if (issue) begin
                        ptr_reg <= ptr_reg + CNT_W'(1);
                    end
                    if (pend_reg) begin
                        if (rd_word == value_reg) begin
                            member_reg <= 1'b1;
                            pos_reg    <= pidx_reg;
                        end else begin
                            if (rd_word < lo_reg) begin
                                lo_reg <= rd_word;
                            end
                            if (rd_word > hi_reg) begin
                                hi_reg <= rd_word;
                            end
                        end
                    end
                    if (!issue && !pend_reg) begin
                        state_reg <= ST_APPLY;
                    end
                end
                ST_APPLY: begin
                    case (func_reg)
                        FUNC_INSERT: begin
                            state_reg <= ST_OUT;
                            if (!member_reg && full) begin
                                rejected_reg <= 1'b1;
                            end else begin
                                if (!member_reg) begin
                                    count_reg <= count_reg + CNT_W'(1);
                                end
                                if (value_reg < lo_reg) begin
                                    lo_reg <= value_reg;
                                end
                                if (value_reg > hi_reg) begin
                                    hi_reg <= value_reg;
                                end
                            end
                        end
                        FUNC_REMOVE: begin
                            if (member_reg) begin
                                ptr_reg   <= CNT_W'(pos_reg) + CNT_W'(1);
                                pend_reg  <= 1'b0;
                                state_reg <= ST_SHIFT;
                            end else begin
                                state_reg <= ST_OUT;
                            end
                        end
                        default: begin
                            state_reg <= ST_OUT;
                            if (member_reg) begin
                                if (value_reg < lo_reg) begin
                                    lo_reg <= value_reg;
                                end
                                if (value_reg > hi_reg) begin
                                    hi_reg <= value_reg;
                                end
                            end
                        end
                    endcase
                end
                ST_SHIFT: begin
                    pend_reg <= issue;
                    pidx_reg <= ptr_reg[IDX_W-1:0];
                    if (issue) begin
                        ptr_reg <= ptr_reg + CNT_W'(1);
                    end
                    if (!issue && !pend_reg) begin
                        count_reg <= count_reg - CNT_W'(1);
                        state_reg <= ST_OUT;
                    end
                end
                ST_OUT: begin
                    if (!m_valid_reg || m_ready) begin
                        m_valid_reg       <= 1'b1;
                        m_was_member      <= member_reg;
                        m_insert_rejected <= rejected_reg;
                        m_count           <= COUNT_W'(count_reg);
                        m_minimum         <= lo_reg;
                        m_maximum         <= hi_reg;
                        state_reg         <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;

endmodule

### dv/set_table_checker.sv
// Scoreboard for the bounded integer set table: predicts every result word
// from the accepted input words and compares it with the block's output.
// Depends on bist_pkg.
`timescale 1ns / 1ps

module set_table_checker
    import bist_pkg::*;
(
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_valid,
    input  logic                     s_ready,
    input  logic [1:0]               s_func,
    input  logic signed [WORD_W-1:0] s_value,
    input  logic                     m_valid,
    input  logic                     m_ready,
    input  logic                     m_was_member,
    input  logic                     m_insert_rejected,
    input  logic [COUNT_W-1:0]       m_count,
    input  logic signed [WORD_W-1:0] m_minimum,
    input  logic signed [WORD_W-1:0] m_maximum,
    output int                       mismatches,
    output int                       outstanding
);

    typedef struct {
        bist_func_t               op;
        logic signed [WORD_W-1:0] operand;
        logic                     was_member;
        logic                     insert_rejected;
        logic [COUNT_W-1:0]       count;
        logic signed [WORD_W-1:0] minimum;
        logic signed [WORD_W-1:0] maximum;
    } set_result_t;

    logic signed [WORD_W-1:0] held [CAPACITY];
    int                       held_n;
    set_result_t              result_q [$];

    initial begin
        mismatches  = 0;
        outstanding = 0;
        held_n      = 0;
    end

    // Applies one word to the shadow set and returns the result it should give.
    function automatic set_result_t apply_word(bist_func_t op,
                                               logic signed [WORD_W-1:0] v);
        set_result_t              r;
        int                       pos;
        int                       i;
        logic signed [WORD_W-1:0] lo;
        logic signed [WORD_W-1:0] hi;
        pos = -1;
        for (i = 0; i < held_n; i++) begin
            if (pos < 0 && held[i] == v)
                pos = i;
        end
        r.op              = op;
        r.operand         = v;
        r.was_member      = (op != FUNC_CLEAR) && (pos >= 0);
        r.insert_rejected = 1'b0;
        case (op)
            FUNC_INSERT: begin
                if (!r.was_member) begin
                    if (held_n >= CAPACITY) begin
                        r.insert_rejected = 1'b1;
                    end else begin
                        held[held_n] = v;
                        held_n++;
                    end
                end
            end
            FUNC_REMOVE: begin
                if (r.was_member) begin
                    for (i = pos; i < held_n - 1; i++)
                        held[i] = held[i + 1];
                    held_n--;
                end
            end
            FUNC_CLEAR: begin
                held_n = 0;
            end
            default: begin
            end
        endcase
        lo = EMPTY_MIN;
        hi = EMPTY_MAX;
        for (i = 0; i < held_n; i++) begin
            if (held[i] < lo)
                lo = held[i];
            if (held[i] > hi)
                hi = held[i];
        end
        r.minimum = lo;
        r.maximum = hi;
        r.count   = held_n[COUNT_W-1:0];
        return r;
    endfunction

    always @(posedge aclk) begin
        set_result_t want;
        if (!aresetn) begin
            held_n = 0;
            result_q.delete();
        end else begin
            if (s_valid && s_ready)
                result_q.push_back(apply_word(bist_func_t'(s_func), s_value));
            if (m_valid && m_ready) begin
                if (result_q.size() == 0) begin
                    if (mismatches < 10)
                        $display("mismatch: result word with none expected");
                    mismatches++;
                end else begin
                    want = result_q.pop_front();
                    if (m_was_member !== want.was_member
                        || m_insert_rejected !== want.insert_rejected
                        || m_count !== want.count
                        || m_minimum !== want.minimum
                        || m_maximum !== want.maximum) begin
                        if (mismatches < 10) begin
                            $display("mismatch: op %s value %0d (exp/got)",
                                     want.op.name(), want.operand);
                            $display("  member %b/%b rejected %b/%b count %0d/%0d",
                                     want.was_member, m_was_member,
                                     want.insert_rejected, m_insert_rejected,
                                     want.count, m_count);
                            $display("  min %0d/%0d max %0d/%0d",
                                     want.minimum, m_minimum,
                                     want.maximum, m_maximum);
                        end
                        mismatches++;
                    end
                end
            end
        end
        outstanding <= result_q.size();
    end

endmodule

### dv/tb.sv
// Testbench top for the bounded integer set table: drives the input words,
// runs the result side with random stalls and gives the verdict.
// Depends on bist_pkg, bounded_integer_set_table and set_table_checker.
`timescale 1ns / 1ps

module tb;
    import bist_pkg::*;

    localparam int PHASE_WORDS  = 500;
    localparam int LONG_HOLD    = 300;
    localparam int IDLE_LIMIT   = 5000;
    localparam int DRAIN_CYCLES = 2 * CAPACITY + 20;
    localparam int POOL_SIZE    = 24;

    logic                     aclk              = 1'b0;
    logic                     aresetn           = 1'b0;
    logic                     s_valid           = 1'b0;
    logic                     s_ready;
    logic [1:0]               s_func            = FUNC_QUERY;
    logic signed [WORD_W-1:0] s_value           = '0;
    logic                     m_valid;
    logic                     m_ready           = 1'b0;
    logic                     m_was_member;
    logic                     m_insert_rejected;
    logic [COUNT_W-1:0]       m_count;
    logic signed [WORD_W-1:0] m_minimum;
    logic signed [WORD_W-1:0] m_maximum;
    int                       mismatches;
    int                       outstanding;

    int                       send_idle_pct  = 0;
    int                       recv_stall_pct = 0;
    logic                     hold_req       = 1'b0;
    int                       quiet_cycles   = 0;
    logic signed [WORD_W-1:0] pool [POOL_SIZE];

    bounded_integer_set_table u_top (.*);

    set_table_checker u_checker (.*);

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // result side: random stalls, or one long hold-off on request
    initial begin
        forever begin
            @(posedge aclk);
            if (hold_req) begin
                m_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge aclk);
                hold_req <= 1'b0;
            end else begin
                m_ready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= IDLE_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    task automatic send_word(input bist_func_t op, input logic signed [WORD_W-1:0] v);
        if ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < send_idle_pct);
        end
        s_valid <= 1'b1;
        s_func  <= op;
        s_value <= v;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        do @(posedge aclk); while (outstanding != 0);
    endtask

    initial begin
        logic signed [WORD_W-1:0] fill_val;
        bist_func_t               op;
        logic signed [WORD_W-1:0] v;
        int                       pick;

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // empty set
        send_word(FUNC_QUERY, '0);
        send_word(FUNC_REMOVE, 32'sd5);
        send_word(FUNC_CLEAR, -32'sd1);
        // fill to capacity, extremes first
        fill_val = '0;
        for (int k = 0; k < CAPACITY; k++) begin
            case (k)
                0:       fill_val = EMPTY_MIN;
                1:       fill_val = EMPTY_MAX;
                2:       fill_val = '0;
                3:       fill_val = -32'sd1;
                default: fill_val = $urandom();
            endcase
            send_word(FUNC_INSERT, fill_val);
        end
        send_word(FUNC_INSERT, 32'sd12345);
        send_word(FUNC_INSERT, -32'sd1);
        send_word(FUNC_QUERY, EMPTY_MAX);
        send_word(FUNC_REMOVE, '0);
        send_word(FUNC_REMOVE, EMPTY_MIN);
        send_word(FUNC_REMOVE, fill_val);
        send_word(FUNC_REMOVE, 32'sd12345);
        send_word(FUNC_CLEAR, '0);
        wait_drained();

        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 67; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 67; end
                default: begin send_idle_pct = 19; recv_stall_pct = 19; end
            endcase
            if (phase == 0)
                hold_req <= 1'b1;
            for (int n = 0; n < PHASE_WORDS; n++) begin
                if (n % 100 == 0) begin
                    for (int k = 0; k < POOL_SIZE; k++) begin
                        case ($urandom_range(7))
                            0:       pool[k] = EMPTY_MIN;
                            1:       pool[k] = EMPTY_MAX;
                            default: pool[k] = $urandom();
                        endcase
                    end
                end
                pick = $urandom_range(99);
                if (pick < 45)
                    op = FUNC_INSERT;
                else if (pick < 75)
                    op = FUNC_REMOVE;
                else if (pick < 97)
                    op = FUNC_QUERY;
                else
                    op = FUNC_CLEAR;
                // mostly pool values so members recur; some stray values
                if ($urandom_range(9) == 0)
                    v = $urandom();
                else
                    v = pool[$urandom_range(POOL_SIZE - 1)];
                send_word(op, v);
            end
            wait_drained();
        end

        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatches == 0 && outstanding == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
